// ===== sv/hcc_pkg.sv =====
// Shared types, constants and register indexes of the hold-to-confirm counter.
package hcc_pkg;

  // Default sizes of the tick counters and of the bounded counter.
  localparam int unsigned DEF_TIME_WIDTH  = 16;
  localparam int unsigned DEF_COUNT_WIDTH = 8;

  // Fixed widths of the configuration registers and of the result fields.
  localparam int unsigned CFG_TIME_W = 16;
  localparam int unsigned CFG_CNT_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COUNT_OUT_W = 8;

  // Progress is Q8: eight fraction bits, one quotient bit per divider step.
  localparam int unsigned Q8_FRAC   = 8;
  localparam int unsigned PROG_W    = Q8_FRAC + 1;
  localparam int unsigned DIV_STEPS = Q8_FRAC;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [PROG_W-1:0] Q8_ONE = PROG_W'(1) << Q8_FRAC;

  // Register reset values.
  localparam logic [CFG_TIME_W-1:0] RST_DISPLAY_TIMEOUT = CFG_TIME_W'(3000);
  localparam logic [CFG_TIME_W-1:0] RST_HOLD_TIME       = CFG_TIME_W'(2000);
  localparam logic [CFG_CNT_W-1:0]  RST_MAX_COUNT       = CFG_CNT_W'(10);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT       = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } hcc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step_en;   // accept a tick: update state, seed the divider
    logic div_en;    // run one divider step
    logic out_load;  // move the finished result into the output register
  } hcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the divider step now running is the last one
  } hcc_stat_t;

  // Single-bit result fields of one tick.
  typedef struct packed {
    logic display_on;
    logic animate_leds;
    logic leds_off;
    logic started_led;
    logic completed_led;
    logic sweep_on;
    logic tone_stop;
    logic confirm_beep;
    logic refresh_display;
    logic enter_error;
  } hcc_flags_t;

endpackage

// ===== sv/hcc_ctrl.sv =====
// Controller state machine of the hold-to-confirm counter.
module hcc_ctrl
  import hcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  hcc_stat_t stat_i,
  output hcc_cmd_t  cmd_o
);

  hcc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (stat_i.div_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.step_en  = accept;
      ST_DIV:  cmd_o.div_en   = 1'b1;
      ST_FIN:  cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken beat");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (in_stall_o && state_q == ST_DIV))
    else $error("input not stalled after an accepted beat");

  a_fin_after_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && $past(state_q) != ST_FIN) |-> $past(stat_i.div_last))
    else $error("finish reached before the divider ran out");

  a_valid_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule

// ===== sv/hcc_dp.sv =====
// Datapath of the hold-to-confirm counter: state, tick update, progress divider, result register.
module hcc_dp
  import hcc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH  = DEF_TIME_WIDTH,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hcc_cmd_t               cmd_i,
  output hcc_stat_t              stat_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   device_pressed_i,
  input  logic                   device_edge_down_i,
  input  logic                   action_pressed_i,
  input  logic                   action_edge_down_i,
  input  logic                   action_edge_up_i,
  output hcc_flags_t             flags_o,
  output logic [PROG_W-1:0]      sweep_progress_o,
  output logic [COUNT_OUT_W-1:0] count_o
);

  localparam int unsigned TCMP_W = (TIME_WIDTH > CFG_TIME_W) ? TIME_WIDTH : CFG_TIME_W;
  localparam int unsigned CCMP_W = (COUNT_WIDTH > CFG_CNT_W) ? COUNT_WIDTH : CFG_CNT_W;
  localparam int unsigned CNT_EXT_W = (COUNT_WIDTH > COUNT_OUT_W) ? COUNT_WIDTH : COUNT_OUT_W;

  // Configuration registers.
  logic [CFG_TIME_W-1:0] display_timeout_q;
  logic [CFG_TIME_W-1:0] hold_time_q;
  logic [CFG_CNT_W-1:0]  max_count_q;

  // Architectural state.
  logic                   display_flag_q, display_flag_d;
  logic                   action_active_q, action_active_d;
  logic                   done_press_q, done_press_d;
  logic                   pend_inc_q, pend_inc_d;
  logic [COUNT_WIDTH-1:0] counter_q, counter_d;
  logic [TIME_WIDTH-1:0]  since_q, since_d;
  logic [TIME_WIDTH-1:0]  held_q, held_d;
  logic                   started_q, started_d;
  logic                   completed_q, completed_d;

  // Tick result waiting for the divider, and the divider itself.
  hcc_flags_t             pflags_q, pflags_d;
  logic                   pfull_q, pfull_d;
  logic [CFG_TIME_W:0]    rem_q, rem_d;
  logic [Q8_FRAC-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0]   dcnt_q, dcnt_d;
  logic [CFG_TIME_W:0]    rem_shift;
  logic [TCMP_W-1:0]      held_ext;
  logic [CNT_EXT_W-1:0]   count_ext;

  // Output register.
  hcc_flags_t             oflags_q;
  logic [PROG_W-1:0]      oprog_q;
  logic [COUNT_OUT_W-1:0] ocount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_timeout_q <= RST_DISPLAY_TIMEOUT;
      hold_time_q       <= RST_HOLD_TIME;
      max_count_q       <= RST_MAX_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DISPLAY_TIMEOUT: display_timeout_q <= cfg_data_i[CFG_TIME_W-1:0];
        REG_HOLD_TIME:       hold_time_q       <= cfg_data_i[CFG_TIME_W-1:0];
        REG_MAX_COUNT:       max_count_q       <= cfg_data_i[CFG_CNT_W-1:0];
        default:             ;
      endcase
    end
  end

  // One tick of the state update, in the order the button events resolve.
  always_comb begin
    logic             ge_hold;
    logic             may_inc;
    logic [TCMP_W-1:0] held_x;
    logic [TCMP_W-1:0] since_x;

    display_flag_d  = display_flag_q;
    action_active_d = action_active_q;
    done_press_d    = done_press_q;
    pend_inc_d      = pend_inc_q;
    counter_d       = counter_q;
    since_d         = since_q;
    held_d          = held_q;
    started_d       = started_q;
    completed_d     = completed_q;
    pflags_d        = '0;
    since_x         = '0;

    if (action_active_q && held_q != '1) held_d = held_q + 1'b1;

    if (device_pressed_i) begin
      since_d = '0;
      if (device_edge_down_i) begin
        display_flag_d        = 1'b1;
        pflags_d.animate_leds = 1'b1;
      end
      if (!done_press_q && action_edge_down_i) begin
        action_active_d = 1'b1;
        held_d          = '0;
        started_d       = 1'b1;
      end
    end else begin
      if (since_q != '1) since_d = since_q + 1'b1;
      since_x = TCMP_W'(since_d);
      if (since_x >= TCMP_W'(display_timeout_q)) begin
        display_flag_d    = 1'b0;
        pflags_d.leds_off = 1'b1;
      end
      if (action_active_q) begin
        action_active_d    = 1'b0;
        started_d          = 1'b0;
        completed_d        = 1'b0;
        pflags_d.tone_stop = 1'b1;
        pend_inc_d         = 1'b0;
      end
      done_press_d = 1'b0;
    end

    held_x  = TCMP_W'(held_d);
    ge_hold = (held_x >= TCMP_W'(hold_time_q));
    pfull_d = ge_hold;

    if (action_active_d) begin
      pflags_d.sweep_on = 1'b1;
      if (!action_pressed_i) begin
        action_active_d    = 1'b0;
        started_d          = 1'b0;
        completed_d        = 1'b0;
        pflags_d.tone_stop = 1'b1;
        pend_inc_d         = 1'b0;
      end
      if (ge_hold && !done_press_d) begin
        done_press_d          = 1'b1;
        pend_inc_d            = 1'b1;
        action_active_d       = 1'b0;
        started_d             = 1'b0;
        completed_d           = 1'b1;
        pflags_d.tone_stop    = 1'b1;
        pflags_d.confirm_beep = 1'b1;
      end
    end

    if (action_edge_up_i) begin
      completed_d        = 1'b0;
      pflags_d.tone_stop = 1'b1;
      action_active_d    = 1'b0;
      may_inc = (CCMP_W'(counter_q) < CCMP_W'(max_count_q)) && (counter_q != '1);
      if (pend_inc_d && may_inc) begin
        counter_d                = counter_q + 1'b1;
        pend_inc_d               = 1'b0;
        pflags_d.refresh_display = 1'b1;
      end
    end else begin
      may_inc = 1'b0;
    end

    if (display_flag_d && !pend_inc_d) pflags_d.refresh_display = 1'b1;

    pflags_d.display_on    = display_flag_d;
    pflags_d.started_led   = started_d;
    pflags_d.completed_led = completed_d;
    pflags_d.enter_error   = (CCMP_W'(counter_d) >= CCMP_W'(max_count_q)) && !device_pressed_i;
  end

  // Restoring division: floor(held * 256 / hold_time), one quotient bit per cycle.
  // It only matters when held < hold_time, so held fits the register width.
  assign rem_shift = {rem_q[CFG_TIME_W-1:0], 1'b0};
  assign held_ext  = TCMP_W'(held_d);
  assign count_ext = CNT_EXT_W'(counter_q);

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dcnt_d = dcnt_q;
    if (cmd_i.step_en) begin
      rem_d  = {1'b0, held_ext[CFG_TIME_W-1:0]};
      quo_d  = '0;
      dcnt_d = '0;
    end else if (cmd_i.div_en) begin
      dcnt_d = dcnt_q + 1'b1;
      if (rem_shift >= {1'b0, hold_time_q}) begin
        rem_d = rem_shift - {1'b0, hold_time_q};
        quo_d = {quo_q[Q8_FRAC-2:0], 1'b1};
      end else begin
        rem_d = rem_shift;
        quo_d = {quo_q[Q8_FRAC-2:0], 1'b0};
      end
    end
  end

  assign stat_o.div_last = (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_flag_q  <= 1'b0;
      action_active_q <= 1'b0;
      done_press_q    <= 1'b0;
      pend_inc_q      <= 1'b0;
      counter_q       <= '0;
      since_q         <= '0;
      held_q          <= '0;
      started_q       <= 1'b0;
      completed_q     <= 1'b0;
      dcnt_q          <= '0;
    end else begin
      if (cmd_i.step_en) begin
        display_flag_q  <= display_flag_d;
        action_active_q <= action_active_d;
        done_press_q    <= done_press_d;
        pend_inc_q      <= pend_inc_d;
        counter_q       <= counter_d;
        since_q         <= since_d;
        held_q          <= held_d;
        started_q       <= started_d;
        completed_q     <= completed_d;
      end
      dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_en) begin
      pflags_q <= pflags_d;
      pfull_q  <= pfull_d;
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.out_load) begin
      oflags_q <= pflags_q;
      ocount_q <= count_ext[COUNT_OUT_W-1:0];
      if (!pflags_q.sweep_on) begin
        oprog_q <= '0;
      end else if (pfull_q) begin
        oprog_q <= Q8_ONE;
      end else begin
        oprog_q <= {1'b0, quo_q};
      end
    end
  end

  assign flags_o          = oflags_q;
  assign sweep_progress_o = oprog_q;
  assign count_o          = ocount_q;

endmodule

// ===== sv/hold_to_confirm_counter.sv =====
// Top level of the hold-to-confirm counter: controller, datapath and port mapping.
//
//  Channel | Handshake                    | Payload
//  --------+------------------------------+---------------------------------------------
//  input   | in_valid_i / in_stall_o      | device/action levels and edges, one tick
//  output  | out_valid_o / out_stall_i    | display, LED, tone flags, progress, count
//  config  | cfg_we_i                     | cfg_idx_i selects, cfg_data_i holds value
//
// Each input beat goes through the state update, then the restoring divider that forms
// the Q8 progress one bit per cycle, then the hand-over to the output register.
// Reset clears the control and tick state and loads the register defaults, but not the
// result, divider data or output registers; there is no clearing pass.
// A result waiting under out_stall_i does not block the next tick: its state update and
// division go ahead, and only the final hand-over waits for the output register.
module hold_to_confirm_counter
  import hcc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH  = DEF_TIME_WIDTH,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   device_pressed_i,
  input  logic                   device_edge_down_i,
  input  logic                   action_pressed_i,
  input  logic                   action_edge_down_i,
  input  logic                   action_edge_up_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   display_on_o,
  output logic                   animate_leds_o,
  output logic                   leds_off_o,
  output logic                   started_led_o,
  output logic                   completed_led_o,
  output logic                   sweep_on_o,
  output logic [PROG_W-1:0]      sweep_progress_o,
  output logic                   tone_stop_o,
  output logic                   confirm_beep_o,
  output logic                   refresh_display_o,
  output logic [COUNT_OUT_W-1:0] count_o,
  output logic                   enter_error_o
);

  hcc_cmd_t   cmd;
  hcc_stat_t  stat;
  hcc_flags_t flags;

  // The controller sequences accept, divide and hand-over.
  hcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, the tick state and the divider.
  hcc_dp #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .device_pressed_i   (device_pressed_i),
    .device_edge_down_i (device_edge_down_i),
    .action_pressed_i   (action_pressed_i),
    .action_edge_down_i (action_edge_down_i),
    .action_edge_up_i   (action_edge_up_i),
    .flags_o            (flags),
    .sweep_progress_o   (sweep_progress_o),
    .count_o            (count_o)
  );

  // The single-bit result fields travel as one struct and fan out here.
  assign display_on_o      = flags.display_on;
  assign animate_leds_o    = flags.animate_leds;
  assign leds_off_o        = flags.leds_off;
  assign started_led_o     = flags.started_led;
  assign completed_led_o   = flags.completed_led;
  assign sweep_on_o        = flags.sweep_on;
  assign tone_stop_o       = flags.tone_stop;
  assign confirm_beep_o    = flags.confirm_beep;
  assign refresh_display_o = flags.refresh_display;
  assign enter_error_o     = flags.enter_error;

endmodule

// ===== tb/sv/tb_hold_to_confirm_counter.sv =====
// Self-checking testbench for the hold-to-confirm counter, with a tick-level model.
`timescale 1ns / 1ps

module tb_hold_to_confirm_counter;
  import hcc_pkg::*;

  // The run is ended by force once it reaches this many clock cycles.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // Each random settings block gets exactly this many button ticks.
  localparam int unsigned TICKS_PER_BLOCK = 267;

  // One input beat: button levels and edges of one millisecond tick.
  // The packed order (dev, dev_down, act, act_down, act_up) is also the bit order
  // of the 5-bit literals in the directed part below.
  typedef struct packed {
    logic dev;
    logic dev_down;
    logic act;
    logic act_down;
    logic act_up;
  } tick_in_t;

  // One output beat: the single-bit flags, the Q8 progress and the count.
  typedef struct packed {
    hcc_flags_t                 flags;
    logic [PROG_W-1:0]          progress;
    logic [COUNT_OUT_W-1:0]     count;
  } tick_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic device_pressed = 1'b0;
  logic device_edge_down = 1'b0;
  logic action_pressed = 1'b0;
  logic action_edge_down = 1'b0;
  logic action_edge_up = 1'b0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   display_on;
  logic                   animate_leds;
  logic                   leds_off;
  logic                   started_led;
  logic                   completed_led;
  logic                   sweep_on;
  logic [PROG_W-1:0]      sweep_progress;
  logic                   tone_stop;
  logic                   confirm_beep;
  logic                   refresh_display;
  logic [COUNT_OUT_W-1:0] count;
  logic                   enter_error;

  hold_to_confirm_counter uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .device_pressed_i   (device_pressed),
    .device_edge_down_i (device_edge_down),
    .action_pressed_i   (action_pressed),
    .action_edge_down_i (action_edge_down),
    .action_edge_up_i   (action_edge_up),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .display_on_o       (display_on),
    .animate_leds_o     (animate_leds),
    .leds_off_o         (leds_off),
    .started_led_o      (started_led),
    .completed_led_o    (completed_led),
    .sweep_on_o         (sweep_on),
    .sweep_progress_o   (sweep_progress),
    .tone_stop_o        (tone_stop),
    .confirm_beep_o     (confirm_beep),
    .refresh_display_o  (refresh_display),
    .count_o            (count),
    .enter_error_o      (enter_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ticks waiting to be sent, and the results that accepted ticks must produce,
  // oldest first.
  tick_in_t  tick_q[$];
  tick_out_t expected_ticks[$];

  // Idle rates in percent; the stimulus process changes them only between blocks.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned ticks_sent = 0;

  // Copy of the register file as the block should hold it.
  logic [CFG_TIME_W-1:0] timeout_cfg = RST_DISPLAY_TIMEOUT;
  logic [CFG_TIME_W-1:0] hold_cfg    = RST_HOLD_TIME;
  logic [CFG_CNT_W-1:0]  limit_cfg   = RST_MAX_COUNT;

  // Model state of the counter, all cleared by reset.
  logic                  disp_lit = 1'b0;
  logic                  act_busy = 1'b0;
  logic                  press_done = 1'b0;
  logic                  inc_pending = 1'b0;
  logic [7:0]            cnt = '0;
  logic [15:0]           since_dev = '0;
  logic [15:0]           held = '0;
  logic                  led_started = 1'b0;
  logic                  led_completed = 1'b0;

  // Levels of the simulated buttons used by the random walk.
  logic walk_dev = 1'b0;
  logic walk_act = 1'b0;

  // Tick currently presented on the input channel.
  tick_in_t  on_bus = '0;
  logic      drv_free;
  tick_out_t seen;
  tick_out_t want;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Q8 hold progress: floor(held * 256 / limit), capped at 1.0. A zero limit or a
  // reached limit both read as complete.
  function automatic logic [PROG_W-1:0] q8_progress(input logic [15:0] h,
                                                    input logic [15:0] lim);
    logic [31:0] q;
    if (lim == 16'd0 || h >= lim) return Q8_ONE;
    q = ({16'd0, h} << Q8_FRAC) / {16'd0, lim};
    return (q > 32'(Q8_ONE)) ? Q8_ONE : q[PROG_W-1:0];
  endfunction

  // Abort of a running action: LEDs go dark and any pending increment is lost.
  task automatic cancel_action();
    act_busy = 1'b0;
    led_started = 1'b0;
    led_completed = 1'b0;
    inc_pending = 1'b0;
  endtask

  // Advances the model by one tick and queues the result the block must produce.
  task automatic predict_tick(input tick_in_t t);
    tick_out_t r;
    r = '0;
    if (act_busy) held = sat_inc(held);

    if (t.dev) begin
      since_dev = '0;
      if (t.dev_down) begin
        disp_lit = 1'b1;
        r.flags.animate_leds = 1'b1;
      end
      // A fresh action edge restarts the hold even when one is already running.
      if (!press_done && t.act_down) begin
        act_busy = 1'b1;
        held = '0;
        led_started = 1'b1;
      end
    end else begin
      since_dev = sat_inc(since_dev);
      // Once the timeout is reached, leds_off pulses on every released tick.
      if (since_dev >= timeout_cfg) begin
        disp_lit = 1'b0;
        r.flags.leds_off = 1'b1;
      end
      if (act_busy) begin
        cancel_action();
        r.flags.tone_stop = 1'b1;
      end
      press_done = 1'b0;
    end

    if (act_busy) begin
      r.progress = q8_progress(held, hold_cfg);
      r.flags.sweep_on = 1'b1;
      if (!t.act) begin
        cancel_action();
        r.flags.tone_stop = 1'b1;
      end
      // Completion is checked even after the cancel above, so an action released
      // on its completing tick still completes and leaves the increment pending.
      if (held >= hold_cfg && !press_done) begin
        press_done = 1'b1;
        inc_pending = 1'b1;
        act_busy = 1'b0;
        led_started = 1'b0;
        led_completed = 1'b1;
        r.flags.tone_stop = 1'b1;
        r.flags.confirm_beep = 1'b1;
      end
    end

    if (t.act_up) begin
      led_completed = 1'b0;
      r.flags.tone_stop = 1'b1;
      act_busy = 1'b0;
      if (inc_pending && cnt < limit_cfg && cnt != 8'hFF) begin
        cnt = cnt + 8'd1;
        inc_pending = 1'b0;
        r.flags.refresh_display = 1'b1;
      end
    end

    if (disp_lit && !inc_pending) r.flags.refresh_display = 1'b1;

    r.flags.display_on = disp_lit;
    r.flags.started_led = led_started;
    r.flags.completed_led = led_completed;
    r.flags.enter_error = (cnt >= limit_cfg) && !t.dev;
    r.count = cnt;
    expected_ticks.push_back(r);
  endtask

  // Input driver: a beat leaves the bus only when accepted, and a new one is
  // loaded at the same edge unless the sender chooses to idle.
  always @(posedge clk) begin
    if (rst_n) begin
      drv_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        predict_tick(on_bus);
        ticks_sent++;
      end
      if (drv_free) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = tick_q.pop_front();
          in_valid <= 1'b1;
          device_pressed <= on_bus.dev;
          device_edge_down <= on_bus.dev_down;
          action_pressed <= on_bus.act;
          action_edge_down <= on_bus.act_down;
          action_edge_up <= on_bus.act_up;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: every accepted beat is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.flags.display_on = display_on;
        seen.flags.animate_leds = animate_leds;
        seen.flags.leds_off = leds_off;
        seen.flags.started_led = started_led;
        seen.flags.completed_led = completed_led;
        seen.flags.sweep_on = sweep_on;
        seen.flags.tone_stop = tone_stop;
        seen.flags.confirm_beep = confirm_beep;
        seen.flags.refresh_display = refresh_display;
        seen.flags.enter_error = enter_error;
        seen.progress = sweep_progress;
        seen.count = count;
        if (expected_ticks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat at cycle %0d: flags %b progress %0d count %0d",
                     cycles, seen.flags, seen.progress, seen.count);
        end else begin
          want = expected_ticks.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              // Flag bits, left to right: display, animate, off, started, completed,
              // sweep, stop, beep, refresh, error.
              $display("mismatch at cycle %0d: flags exp %b got %b", cycles,
                       want.flags, seen.flags);
              $display("  progress exp %0d got %0d, count exp %0d got %0d",
                       want.progress, seen.progress, want.count, seen.count);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Register writes happen only while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DISPLAY_TIMEOUT: timeout_cfg = value[15:0];
      REG_HOLD_TIME:       hold_cfg = value[15:0];
      REG_MAX_COUNT:       limit_cfg = value[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_registers(input int unsigned timeout_v, input int unsigned hold_v,
                               input int unsigned limit_v);
    write_reg(REG_DISPLAY_TIMEOUT, timeout_v);
    write_reg(REG_HOLD_TIME, hold_v);
    write_reg(REG_MAX_COUNT, limit_v);
  endtask

  // Waits on falling edges, so the checks never race the clocked processes.
  task automatic wait_all_done();
    @(negedge clk);
    while (tick_q.size() != 0 || in_valid || expected_ticks.size() != 0)
      @(negedge clk);
  endtask

  // Button presses as a random walk of the two levels, with edges that agree with
  // the levels, plus a small share of arbitrary bit patterns as noise.
  task automatic queue_button_walk(input int unsigned n);
    tick_in_t t;
    logic     dev_next;
    logic     act_next;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        t = tick_in_t'(5'($urandom_range(31)));
      end else begin
        dev_next = ($urandom_range(99) < 5) ? !walk_dev : walk_dev;
        act_next = ($urandom_range(99) < 10) ? !walk_act : walk_act;
        t.dev = dev_next;
        t.dev_down = dev_next && !walk_dev;
        t.act = act_next;
        t.act_down = act_next && !walk_act;
        t.act_up = !act_next && walk_act;
        walk_dev = dev_next;
        walk_act = act_next;
      end
      tick_q.push_back(t);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 14;
    recv_stall_pct = 50;

    // Zero timeout, zero hold time and a zero limit.
    set_registers(0, 0, 0);
    tick_q.push_back(5'b00000);  // released: display off at once, error at limit 0
    tick_q.push_back(5'b11110);  // press both: action starts and completes at once
    tick_q.push_back(5'b10001);  // action released: no increment at limit 0
    tick_q.push_back(5'b00000);  // device released
    tick_q.push_back(5'b00000);  // the timeout pulse repeats
    wait_all_done();

    set_registers(2, 3, 1);
    tick_q.push_back(5'b11000);  // device down, display on
    tick_q.push_back(5'b10110);  // action starts
    tick_q.push_back(5'b10100);
    tick_q.push_back(5'b10110);  // new action edge restarts the hold
    tick_q.push_back(5'b10100);
    tick_q.push_back(5'b10100);
    tick_q.push_back(5'b10100);  // hold time reached: beep
    tick_q.push_back(5'b10001);  // release increments to the limit
    tick_q.push_back(5'b10110);  // no second start within the same press
    tick_q.push_back(5'b00000);
    tick_q.push_back(5'b00000);  // display times out
    tick_q.push_back(5'b11110);
    tick_q.push_back(5'b10100);
    tick_q.push_back(5'b10100);
    tick_q.push_back(5'b10000);  // released on the completing tick
    tick_q.push_back(5'b01011);  // edges that contradict the levels
    tick_q.push_back(5'b11111);
    wait_all_done();

    set_registers(16'hFFFF, 16'hFFFF, 8'hFF);
    tick_q.push_back(5'b11110);
    tick_q.push_back(5'b10100);  // tiny progress against the largest hold time
    tick_q.push_back(5'b00001);
    wait_all_done();

    // Random part: six settings blocks; the first two with a slow receiver, the
    // next two with a slow sender, the last two with no idling at all.
    for (int unsigned blk = 0; blk < 6; blk++) begin
      case (blk / 2)
        0: begin
          send_idle_pct = 14;
          recv_stall_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_stall_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (blk)
        0: set_registers($urandom_range(40), $urandom_range(1, 12), 3);
        1: set_registers($urandom_range(3), $urandom_range(1, 30), 255);
        2: set_registers($urandom_range(5, 50), 1, $urandom_range(2, 6));
        3: set_registers(20, $urandom_range(2, 8), (cnt < 8'd250) ? cnt + 2 : 255);
        4: set_registers($urandom_range(30), $urandom_range(1, 20), $urandom_range(1, 255));
        default: set_registers($urandom_range(60), $urandom_range(1, 10), 255);
      endcase
      queue_button_walk(TICKS_PER_BLOCK);
      wait_all_done();
    end

    // Let any stray beat show up before the verdict.
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
